@@ src/circle_outline_fill_rasterizer_top_assert.svh @@
// Assertion macros shared by the circle rasterizer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef CIRCLE_OUTLINE_FILL_RASTERIZER_TOP_ASSERT_SVH
`define CIRCLE_OUTLINE_FILL_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while the given condition is high.
`define COFR_ASSERT_IMP(name, clk, dis, ante, cons) \
  name: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("cofr assertion failed");

// Next-cycle implication, disabled while the given condition is high.
`define COFR_ASSERT_NXT(name, clk, dis, ante, cons) \
  name: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("cofr assertion failed");

`endif

@@ src/cofr_pkg.sv @@
// Shared types and constants of the circle outline/fill rasterizer.
// No dependencies; used by the top level and its checker.
package cofr_pkg;

  // Fixed field widths of the ports and of the result index.
  localparam int COORD_W  = 16;
  localparam int CTR_W    = 15;
  localparam int RAD_IN_W = 14;
  localparam int IDX_W    = 3;

  // Index of the final result of a step in each mode.
  localparam logic [IDX_W-1:0] LAST_OUTLINE = 3'd7;
  localparam logic [IDX_W-1:0] LAST_FILL    = 3'd3;

  // Request codes on the input channel.
  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_t;

  // One step's worth of geometry, handed from the stepper to the result sequencer.
  typedef struct packed {
    logic signed [CTR_W-1:0] ctr_x;
    logic signed [CTR_W-1:0] ctr_y;
    logic [COORD_W-1:0]      off_a;
    logic [COORD_W-1:0]      off_b;
    logic                    fill;
    logic                    done;
  } step_t;

endpackage

@@ src/circle_outline_fill_rasterizer_top.sv @@
// Top level of the circle outline/fill rasterizer.
// Depends on cofr_pkg for the step record, field widths and request codes.
//
// A start transaction loads the centre, radius and mode and gives
// no result. Each advance transaction runs one midpoint-style iteration in the
// cycle it is accepted and queues its geometry: an outline step then delivers
// eight points and a fill step four horizontal spans, one result per cycle
// while out_stall is low, through the single result port. One step can wait
// behind the step being delivered; in_stall is high only while that waiting
// slot is full. An advance with no circle in progress is accepted and gives
// nothing. RADIUS_BITS sets the radius and decision-variable widths
// (4 to 16).
module circle_outline_fill_rasterizer_top #(
  parameter int RADIUS_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic signed [14:0] center_x,
  input  logic signed [14:0] center_y,
  input  logic [13:0] radius,
  input  logic        fill_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] x_begin,
  output logic signed [15:0] x_finish,
  output logic signed [15:0] row_y,
  output logic        last_of_step,
  output logic        circle_done
);

  localparam int DecW = RADIUS_BITS + 3;
  localparam int OffW = RADIUS_BITS + 2;
  localparam int CW   = cofr_pkg::COORD_W;
  localparam logic [DecW-1:0] DecOne = DecW'(1);
  localparam logic [OffW-1:0] OffOne = OffW'(1);

  // Circle state.
  logic signed [14:0]      ctr_x;
  logic signed [14:0]      ctr_y;
  logic [RADIUS_BITS-1:0]  rad;
  logic [RADIUS_BITS-1:0]  off_x;
  logic [RADIUS_BITS-1:0]  off_y;
  logic [DecW-1:0]         decision;
  logic                    fill_sel;
  logic                    active;

  // Result sequencer state.
  cofr_pkg::step_t         cur;
  logic                    cur_valid;
  logic [cofr_pkg::IDX_W-1:0] idx;
  cofr_pkg::step_t         pend;
  logic                    pend_valid;

  logic                    in_fire;
  logic                    is_start;
  logic                    step_fire;
  logic                    out_fire;
  logic                    at_last;
  logic                    slot_free;
  logic [RADIUS_BITS-1:0]  rad_in;
  logic [DecW-1:0]         dec_start;

  logic signed [DecW-1:0]  dec_s;
  logic signed [DecW-1:0]  two_a;
  logic signed [DecW-1:0]  two_gap;
  logic [DecW-1:0]         a_d;
  logic [DecW-1:0]         b_d;
  logic [DecW-1:0]         rad_d;
  logic [DecW-1:0]         decision_next;
  logic signed [OffW-1:0]  a_w;
  logic signed [OffW-1:0]  b_w;
  logic signed [OffW-1:0]  a_n;
  logic signed [OffW-1:0]  b_n;
  logic                    step_done;
  logic [RADIUS_BITS-1:0]  off_x_next;
  logic [RADIUS_BITS-1:0]  off_y_next;
  cofr_pkg::step_t         snap;

  // Handshake decode.
  assign in_fire   = in_valid && !in_stall;
  assign is_start  = (cofr_pkg::req_t'(req_type) == cofr_pkg::REQ_START);
  assign step_fire = in_fire && !is_start && active;
  assign in_stall  = pend_valid;

  // Values loaded by a start transaction.
  assign rad_in    = RADIUS_BITS'(radius);
  assign dec_start = DecW'(rad_in) - DecOne;

  // One iteration of the decision-variable rule.
  always_comb begin
    a_d     = DecW'(off_x);
    b_d     = DecW'(off_y);
    rad_d   = DecW'(rad);
    dec_s   = decision;
    two_a   = a_d << 1;
    two_gap = (rad_d - b_d) << 1;
    a_w     = OffW'(off_x);
    b_w     = OffW'(off_y);
    if (dec_s >= two_a) begin
      decision_next = DecW'(decision - (a_d << 1) - DecOne);
      a_n = a_w + OffOne;
      b_n = b_w;
    end else if (dec_s < two_gap) begin
      decision_next = DecW'(decision + (b_d << 1) - DecOne);
      a_n = a_w;
      b_n = b_w - OffOne;
    end else begin
      decision_next = DecW'(decision + ((b_d - a_d - DecOne) << 1));
      a_n = a_w + OffOne;
      b_n = b_w - OffOne;
    end
    step_done  = (b_n < a_n);
    off_x_next = a_n[RADIUS_BITS-1:0];
    if (step_done && b_n[OffW-1]) begin
      off_y_next = '0;
    end else begin
      off_y_next = b_n[RADIUS_BITS-1:0];
    end
  end

  // Geometry of the step being taken, before the offsets move.
  always_comb begin
    snap.ctr_x = ctr_x;
    snap.ctr_y = ctr_y;
    snap.off_a = CW'(off_x);
    snap.off_b = CW'(off_y);
    snap.fill  = fill_sel;
    snap.done  = step_done;
  end

  // Circle state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_x    <= '0;
      ctr_y    <= '0;
      rad      <= '0;
      off_x    <= '0;
      off_y    <= '0;
      decision <= '0;
      fill_sel <= 1'b0;
      active   <= 1'b0;
    end else if (in_fire && is_start) begin
      ctr_x    <= center_x;
      ctr_y    <= center_y;
      rad      <= rad_in;
      off_x    <= '0;
      off_y    <= rad_in;
      decision <= dec_start;
      fill_sel <= fill_mode;
      active   <= 1'b1;
    end else if (step_fire) begin
      off_x    <= off_x_next;
      off_y    <= off_y_next;
      decision <= decision_next;
      active   <= !step_done;
    end
  end

  // Result sequencer control.
  assign out_fire  = cur_valid && !out_stall;
  assign at_last   = (idx == (cur.fill ? cofr_pkg::LAST_FILL : cofr_pkg::LAST_OUTLINE));
  assign slot_free = !cur_valid || (out_fire && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (slot_free) begin
        idx <= '0;
        if (pend_valid) begin
          cur_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else begin
          cur_valid <= step_fire;
        end
      end else begin
        if (out_fire) begin
          idx <= idx + 1'b1;
        end
        if (step_fire) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  // Step records in flight; the valid flags above qualify them.
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid) begin
        cur <= pend;
      end else if (step_fire) begin
        cur <= snap;
      end
    end else if (step_fire) begin
      pend <= snap;
    end
  end

  // Result fields for the current index within the step.
  logic [CW-1:0] cx;
  logic [CW-1:0] cy;
  logic [CW-1:0] xo;
  logic [CW-1:0] yo;
  logic          xneg;
  logic          yneg;
  logic          x_use_b;

  always_comb begin
    cx = CW'($signed(cur.ctr_x));
    cy = CW'($signed(cur.ctr_y));
    if (cur.fill) begin
      x_use_b = (idx[0] == idx[1]);
      xneg    = 1'b0;
      yneg    = idx[1];
    end else begin
      x_use_b = idx[0];
      xneg    = idx[1];
      yneg    = idx[2];
    end
    xo = x_use_b ? cur.off_b : cur.off_a;
    yo = x_use_b ? cur.off_a : cur.off_b;
    if (cur.fill) begin
      x_begin  = cx - xo;
      x_finish = cx + xo;
    end else begin
      x_begin  = xneg ? (cx - xo) : (cx + xo);
      x_finish = x_begin;
    end
    row_y = yneg ? (cy - yo) : (cy + yo);
  end

  assign out_valid    = cur_valid;
  assign last_of_step = at_last;
  assign circle_done  = at_last && cur.done;

endmodule

@@ src/cofr_checker.sv @@
// Port-level checker for the circle rasterizer, bound to the top level.
// Depends on cofr_pkg and the circle_outline_fill_rasterizer_top_assert.svh macros.
`include "circle_outline_fill_rasterizer_top_assert.svh"

module cofr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [15:0] x_begin,
  input logic signed [15:0] x_finish,
  input logic signed [15:0] row_y,
  input logic        last_of_step,
  input logic        circle_done
);

  logic        in_advance;
  logic [49:0] out_fields;

  assign in_advance = in_valid &&
                      (cofr_pkg::req_t'(req_type) == cofr_pkg::REQ_ADVANCE);
  assign out_fields = {x_begin, x_finish, row_y, last_of_step, circle_done};

  // A result transaction held by stall keeps its fields.
  `COFR_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_fields))

  // The circle can only finish on the final result of a step.
  `COFR_ASSERT_IMP(a_done_last, clk, rst, out_valid && circle_done, last_of_step)

  // Reset leaves no result pending and the input open.
  `COFR_ASSERT_NXT(a_reset_clear, clk, 1'b0, rst, !out_valid && !in_stall)

  // The input only stalls after an advance transaction has been taken.
  `COFR_ASSERT_IMP(a_stall_cause, clk, rst, $rose(in_stall), $past(in_advance))

endmodule

bind circle_outline_fill_rasterizer_top cofr_checker u_cofr_checker (.*);
